@@ rtl/core/svm_pkg.sv @@
// Shared types and constants for the linear SVM SGD trainer.
// No dependencies; imported by the lane, merge and top-level modules.
package svm_pkg;

  localparam int LANES = 8;
  localparam int FEAT_W = 16;
  localparam int WGT_W = 32;
  localparam int PROD_W = FEAT_W + WGT_W;
  localparam int SUM_W = PROD_W + 3;
  localparam int CFG_W = 16;

  localparam logic [1:0] KIND_TRAIN = 2'd0;
  localparam logic [1:0] KIND_PREDICT = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic CFG_LEARNING_RATE = 1'b0;
  localparam logic CFG_REG_LAMBDA = 1'b1;

  localparam logic [15:0] LR_RESET = 16'd66;
  localparam logic [15:0] LAMBDA_RESET = 16'd655;
  localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

  localparam logic signed [WGT_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [WGT_W-1:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic capture;  // register products, decay and step
    logic update;   // write the new weight
    logic met;      // margin reached, no hinge step
    logic pos;      // label is +1
  } lane_ctrl_t;

  typedef struct packed {
    logic add1;     // pairwise sums
    logic add2;     // final sum
  } merge_ctrl_t;

endpackage

@@ rtl/core/svm_lane.sv @@
// One feature lane: product for the dot product, decay and hinge step,
// and the weight register itself. Depends on svm_pkg.
module svm_lane (
  input  logic                                   clk,
  input  logic                                   rst,
  input  svm_pkg::lane_ctrl_t                    ctrl,
  input  logic signed [svm_pkg::FEAT_W-1:0]      feature,
  input  logic [31:0]                            decay_coef,
  input  logic [svm_pkg::CFG_W-1:0]              learning_rate,
  output logic signed [svm_pkg::WGT_W-1:0]       weight,
  output logic signed [svm_pkg::PROD_W-1:0]      product
);
  import svm_pkg::*;

  logic signed [64:0] decay_full;
  logic signed [32:0] step_full;
  logic signed [33:0] decay;
  logic signed [24:0] step;
  logic signed [35:0] nw;
  logic signed [WGT_W-1:0] nw_sat;

  assign decay_full = weight * $signed({1'b0, decay_coef});
  assign step_full = $signed({1'b0, learning_rate}) * feature;

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      product <= feature * weight;
      decay <= decay_full[64:31];
      step <= step_full[32:8];
    end
  end

  always_comb begin
    nw = 36'(weight) - 36'(decay);
    if (!ctrl.met) begin
      if (ctrl.pos) nw = nw + 36'(step);
      else nw = nw - 36'(step);
    end
    if (nw > 36'(SAT_MAX)) nw_sat = SAT_MAX;
    else if (nw < 36'(SAT_MIN)) nw_sat = SAT_MIN;
    else nw_sat = nw[WGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
    end else if (ctrl.update) begin
      weight <= nw_sat;
    end
  end

endmodule

@@ rtl/core/svm_merge.sv @@
// Registered two-level adder tree over the lane products.
// Depends on svm_pkg.
module svm_merge (
  input  logic                                         clk,
  input  svm_pkg::merge_ctrl_t                         ctrl,
  input  logic signed [svm_pkg::PROD_W-1:0]            product [svm_pkg::LANES],
  output logic signed [svm_pkg::SUM_W-1:0]             sum
);
  import svm_pkg::*;

  logic signed [PROD_W:0] pair [LANES/2];

  always_ff @(posedge clk) begin
    if (ctrl.add1) begin
      for (int i = 0; i < LANES/2; i++) begin
        pair[i] <= (PROD_W+1)'(product[2*i]) + (PROD_W+1)'(product[2*i+1]);
      end
    end
    if (ctrl.add2) begin
      sum <= SUM_W'(pair[0]) + SUM_W'(pair[1]) + SUM_W'(pair[2]) + SUM_W'(pair[3]);
    end
  end

endmodule

@@ rtl/core/linear_svm_sgd_trainer_unit.sv @@
// Top level of the linear SVM SGD trainer: sequencer, bias, lanes, merge.
// Depends on svm_pkg, svm_lane, svm_merge.
//
//  channel  | dir | handshake          | payload
//  s_axis   | in  | tvalid/tready      | tdata: features, label, read index; tuser: kind
//  m_axis   | out | tvalid/tready      | tdata: decision, class, margin, weight, bias
//  cfg      | in  | cfg_we (no wait)   | cfg_index, cfg_data
//
// One transaction at a time: from accept to result the sequencer steps through
// capture, two adder-tree levels, decision, margin/update and output load,
// and s_axis_tready is high only in idle, which it reaches after the output load.
// The serial chain multiply -> tree -> compare -> update sets this sequence.
// A new transaction is taken while the previous result waits in the output
// register; a stalled m_axis holds the sequencer in its output-load step.
// Reset (rst, synchronous) clears weights, bias and valid flags and loads the config reset values.
module linear_svm_sgd_trainer_unit #(
  parameter int FEAT_COUNT = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [127:0] feature_0..feature_7 (16 b each, feature_0 lowest),
  // [128] label_positive, [131:129] read_index, [135:132] zero
  input  logic [135:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] decision_value, [32] predicted_class, [33] margin_met,
  // [65:34] weight_value, [97:66] bias_value, [103:98] zero
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);
  import svm_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_ADD1 = 3'd2;
  localparam logic [2:0] ST_ADD2 = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state, state_next;

  // config and derived decay coefficient lr*lambda (Q0.32)
  logic [CFG_W-1:0] learning_rate, reg_lambda;
  logic [31:0] decay_coef;

  // item registers
  logic [1:0] kind;
  logic pos;
  logic [2:0] read_index;
  logic signed [FEAT_W-1:0] feature [LANES];

  logic signed [WGT_W-1:0] bias;
  logic signed [WGT_W-1:0] dec;
  logic met;
  logic met_now;

  logic signed [WGT_W-1:0] weight [LANES];
  logic signed [PROD_W-1:0] product [LANES];
  logic signed [SUM_W-1:0] sum;

  lane_ctrl_t lctrl;
  merge_ctrl_t mctrl;

  logic in_fire, out_load, is_train;
  logic signed [43:0] dec_wide;
  logic signed [32:0] yd;
  logic signed [32:0] bias_wide;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);
  assign is_train = (kind == KIND_TRAIN);

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      reg_lambda <= LAMBDA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEARNING_RATE: learning_rate <= cfg_data;
        CFG_REG_LAMBDA: reg_lambda <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    decay_coef <= learning_rate * reg_lambda;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < LANES; i++) begin
        feature[i] <= s_axis_tdata[FEAT_W*i +: FEAT_W];
      end
      pos <= s_axis_tdata[128];
      read_index <= s_axis_tdata[131:129];
      kind <= s_axis_tuser;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD1;
      ST_ADD1: state_next = ST_ADD2;
      ST_ADD2: state_next = ST_DEC;
      ST_DEC:  state_next = ST_UPD;
      ST_UPD:  state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  assign lctrl.capture = (state == ST_MUL);
  assign lctrl.update = (state == ST_UPD) && is_train;
  assign lctrl.met = met_now;
  assign lctrl.pos = pos;
  assign mctrl.add1 = (state == ST_ADD1);
  assign mctrl.add2 = (state == ST_ADD2);

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    if (g < FEAT_COUNT) begin : g_used
      svm_lane u_lane (
        .clk(clk), .rst(rst), .ctrl(lctrl), .feature(feature[g]),
        .decay_coef(decay_coef), .learning_rate(learning_rate),
        .weight(weight[g]), .product(product[g])
      );
    end else begin : g_unused
      // features past FEAT_COUNT are ignored, their weights stay zero
      assign weight[g] = '0;
      assign product[g] = '0;
    end
  end

  svm_merge u_merge (.clk(clk), .ctrl(mctrl), .product(product), .sum(sum));

  // decision: floor(sum / 2^8) - bias, saturated
  assign dec_wide = 44'($signed(sum[SUM_W-1:8])) - 44'(bias);
  assign yd = pos ? 33'(dec) : -33'(dec);

  always_ff @(posedge clk) begin
    if (state == ST_DEC) begin
      if (kind == KIND_TRAIN || kind == KIND_PREDICT) begin
        if (dec_wide > 44'(SAT_MAX)) dec <= SAT_MAX;
        else if (dec_wide < 44'(SAT_MIN)) dec <= SAT_MIN;
        else dec <= dec_wide[WGT_W-1:0];
      end else begin
        dec <= '0;
      end
    end
  end

  // margin test on the registered decision, used by the update step;
  // only train items can meet the margin
  assign met_now = is_train && (yd >= ONE_Q16);

  always_ff @(posedge clk) begin
    if (rst) met <= 1'b0;
    else if (state == ST_UPD) met <= met_now;
  end

  // bias moves against the label when the margin is missed
  assign bias_wide = pos ? 33'(bias) - 33'($signed({1'b0, learning_rate}))
                         : 33'(bias) + 33'($signed({1'b0, learning_rate}));

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (lctrl.update && !met_now) begin
      if (bias_wide > 33'(SAT_MAX)) bias <= SAT_MAX;
      else if (bias_wide < 33'(SAT_MIN)) bias <= SAT_MIN;
      else bias <= bias_wide[WGT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {6'd0, bias, weight[read_index], met,
                       (kind == KIND_TRAIN || kind == KIND_PREDICT) && !dec[WGT_W-1],
                       dec};
    end
  end

endmodule

@@ rtl/core/svm_checker.sv @@
// Port-level checks for the linear SVM SGD trainer, bound to the top level.
// Depends on linear_svm_sgd_trainer_unit only through the bind.
module svm_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  // one transaction in flight: busy right after accepting
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // predicted class implies non-negative decision value
  a_class: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[32] |-> !m_axis_tdata[31])
    else $error("class disagrees with decision sign");

  // margin met with a non-negative decision needs decision >= 1.0
  a_margin: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[33] && !m_axis_tdata[31] |-> m_axis_tdata[31:16] != 16'd0)
    else $error("margin met below one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind linear_svm_sgd_trainer_unit svm_checker u_svm_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
